>>> hw/rtl/mh2_pkg.sv
package mh2_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned LenW  = 31;
  localparam int unsigned NbW   = 3;

  localparam logic [WordW-1:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned      MixShift  = 24;
  localparam int unsigned      FinShiftA = 13;
  localparam int unsigned      FinShiftB = 15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_MIX4,
    S_TAIL1,
    S_TAIL2,
    S_FIN1,
    S_FOUT
  } state_e;

  typedef enum logic [2:0] {
    OP_WORD,
    OP_K,
    OP_H,
    OP_TAIL,
    OP_FIN
  } op_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    op_sel_e op_sel;
    logic    k_save;
    logic    h_mix;
    logic    h_tail;
    logic    out_load;
  } ctrl_t;

  // keep only the valid tail bytes; a non-last word or 4+ bytes is a full word
  function automatic logic [WordW-1:0] tail_mask(logic [NbW-1:0] nbytes, logic last);
    logic [WordW-1:0] m;
    m = '1;
    if (last) begin
      case (nbytes)
        3'd0:    m = '0;
        3'd1:    m = 32'h0000_00ff;
        3'd2:    m = 32'h0000_ffff;
        3'd3:    m = 32'h00ff_ffff;
        default: m = '1;
      endcase
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/mh2_mul.sv
module mh2_mul
  import mh2_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WordW-1:0] a_i,
  output logic [WordW-1:0] p_o
);

  logic [WordW-1:0] p_q;
  logic [WordW-1:0] p_d;

  assign p_d = a_i * MixMul;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/mh2_ctrl.sv
module mh2_ctrl
  import mh2_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  go_i,
  input  logic  full_i,
  input  logic  tail_i,
  input  logic  last_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          if (full_i) begin
            state_d = S_MIX1;
          end else if (tail_i) begin
            state_d = S_TAIL1;
          end else begin
            state_d = S_FIN1;
          end
        end
      end
      S_MIX1:  state_d = S_MIX2;
      S_MIX2:  state_d = S_MIX3;
      S_MIX3:  state_d = S_MIX4;
      S_MIX4:  state_d = last_i ? S_FIN1 : S_IDLE;
      S_TAIL1: state_d = S_TAIL2;
      S_TAIL2: state_d = S_FIN1;
      S_FIN1:  state_d = S_FOUT;
      S_FOUT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.op_sel = OP_WORD;
    case (state_q)
      S_IDLE: ctrl_o.in_ready = 1'b1;
      S_MIX1: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = OP_WORD;
      end
      S_MIX2: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = OP_K;
      end
      S_MIX3: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = OP_H;
        ctrl_o.k_save = 1'b1;
      end
      S_MIX4: ctrl_o.h_mix = 1'b1;
      S_TAIL1: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = OP_TAIL;
      end
      S_TAIL2: ctrl_o.h_tail = 1'b1;
      S_FIN1: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = OP_FIN;
      end
      S_FOUT: ctrl_o.out_load = out_free_i;
      default: ctrl_o = '0;
    endcase
  end

endmodule

>>> hw/rtl/murmur2_hash_engine.sv
// Streaming 32-bit MurmurHash2 engine. Words enter one at a time; the first
// word of a message loads seed ^ length, the last word carries 0..4 valid
// bytes and produces one hash. All multiplies by the mixing constant go
// through one registered multiplier, so the input stalls while a word is
// worked on: a full word runs through S_MIX1 to S_MIX4, a partial tail
// through S_TAIL1 and S_TAIL2, and a last word then runs S_FIN1 for the
// avalanche and waits in S_FOUT until the hash is loaded into the output
// register, which can hold a finished hash while the next word is accepted.
module murmur2_hash_engine
  import mh2_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             hash_seed_we_i,
  input  logic [WordW-1:0] hash_seed_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] data_word_i,
  input  logic [NbW-1:0]   valid_bytes_i,
  input  logic             is_first_i,
  input  logic             is_last_i,
  input  logic [LenW-1:0]  total_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] hash_value_o
);

  ctrl_t            ctrl;
  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] h_q;
  logic [WordW-1:0] word_q;
  logic             last_q;
  logic             msg_q;
  logic             out_valid_q;
  logic [WordW-1:0] out_hash_q;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] mul_a;
  logic             in_fire;
  logic             go;
  logic             full;
  logic             tail;
  logic             out_free;

  assign in_stall_o = ~ctrl.in_ready;
  assign in_fire    = in_valid_i & ctrl.in_ready;
  assign go         = in_fire & (is_first_i | msg_q);
  assign full       = ~is_last_i | (valid_bytes_i >= NbW'(4));
  assign tail       = valid_bytes_i != '0;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  mh2_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .go_i       (go),
    .full_i     (full),
    .tail_i     (tail),
    .last_i     (last_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    case (ctrl.op_sel)
      OP_WORD: mul_a = word_q;
      OP_K:    mul_a = prod ^ (prod >> MixShift);
      OP_H:    mul_a = h_q;
      OP_TAIL: mul_a = h_q ^ word_q;
      OP_FIN:  mul_a = h_q ^ (h_q >> FinShiftA);
      default: mul_a = word_q;
    endcase
  end

  mh2_mul u_mul (
    .clk_i,
    .en_i (ctrl.mul_en),
    .a_i  (mul_a),
    .p_o  (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      h_q         <= '0;
      msg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (hash_seed_we_i) begin
        seed_q <= hash_seed_i;
      end
      if (in_fire && is_first_i) begin
        h_q   <= seed_q ^ {1'b0, total_length_i};
        msg_q <= 1'b1;
      end else if (ctrl.h_mix) begin
        h_q <= prod ^ word_q;
      end else if (ctrl.h_tail) begin
        h_q <= prod;
      end
      if (ctrl.out_load) begin
        msg_q <= 1'b0;
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q <= data_word_i & tail_mask(valid_bytes_i, is_last_i);
      last_q <= is_last_i;
    end else if (ctrl.k_save) begin
      word_q <= prod;
    end
    if (ctrl.out_load) begin
      out_hash_q <= prod ^ (prod >> FinShiftB);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

  a_ignored_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !is_first_i && !msg_q |=> !in_stall_o)
    else $error("ignored word left engine busy");

  a_first_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && is_first_i |=> msg_q && in_stall_o)
    else $error("first word did not open a message");

  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(msg_q) |-> out_valid_o)
    else $error("message closed without a hash");

endmodule

>>> tb/tb_murmur2_hash_engine.sv
`timescale 1ns / 1ps

module tb_murmur2_hash_engine;
  import mh2_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 30;

  typedef struct {
    logic [WordW-1:0] data;
    logic [NbW-1:0]   nb;
    logic             first;
    logic             last;
    logic [LenW-1:0]  len;
  } msg_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             hash_seed_we_i = 1'b0;
  logic [WordW-1:0] hash_seed_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [WordW-1:0] data_word_i = '0;
  logic [NbW-1:0]   valid_bytes_i = '0;
  logic             is_first_i = 1'b0;
  logic             is_last_i = 1'b0;
  logic [LenW-1:0]  total_length_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [WordW-1:0] hash_value_o;

  murmur2_hash_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hash_seed_we_i(hash_seed_we_i),
    .hash_seed_i   (hash_seed_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .is_first_i    (is_first_i),
    .is_last_i     (is_last_i),
    .total_length_i(total_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hash_value_o  (hash_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  msg_word_t        word_q[$];
  logic [WordW-1:0] hash_q[$];

  logic [WordW-1:0] seed_mdl = '0;
  logic [WordW-1:0] hash_mdl = '0;
  bit               open_mdl = 1'b0;

  int unsigned issued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned useful_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          gen_open = 1'b0;

  function automatic logic [WordW-1:0] mix_block(logic [WordW-1:0] h, logic [WordW-1:0] w);
    logic [WordW-1:0] k;
    logic [WordW-1:0] hm;
    k = w * MixMul;
    k = k ^ (k >> MixShift);
    k = k * MixMul;
    hm = h * MixMul;
    return hm ^ k;
  endfunction

  function automatic logic [WordW-1:0] avalanche(logic [WordW-1:0] h);
    logic [WordW-1:0] x;
    x = h ^ (h >> FinShiftA);
    x = x * MixMul;
    x = x ^ (x >> FinShiftB);
    return x;
  endfunction

  task automatic absorb_word(input msg_word_t w);
    logic [WordW-1:0] h;
    logic [WordW-1:0] mask;
    if (w.first) begin
      hash_mdl = seed_mdl ^ {1'b0, w.len};
      open_mdl = 1'b1;
    end
    if (open_mdl) begin
      h = hash_mdl;
      if (!w.last || w.nb >= 3'd4) begin
        h = mix_block(h, w.data);
      end else if (w.nb != 3'd0) begin
        mask = ~({WordW{1'b1}} << (8 * w.nb));
        h = h ^ (w.data & mask);
        h = h * MixMul;
      end
      hash_mdl = h;
      if (w.last) begin
        open_mdl = 1'b0;
        hash_q.push_back(avalanche(h));
      end
    end
  endtask

  task automatic report(input string what, input logic [WordW-1:0] got,
                        input logic [WordW-1:0] want);
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // driver
  int        in_gap = 0;
  bit        in_calm = 1'b0;
  msg_word_t cur_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (word_q.size() != 0) begin
        cur_word = word_q.pop_front();
        data_word_i    <= cur_word.data;
        valid_bytes_i  <= cur_word.nb;
        is_first_i     <= cur_word.first;
        is_last_i      <= cur_word.last;
        total_length_i <= cur_word.len;
        in_valid_i     <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted words, checks accepted hashes, drives stall
  int               out_hold = 0;
  int               out_hold_n;
  bit               out_calm = 1'b0;
  msg_word_t        seen_word;
  logic [WordW-1:0] want_hash;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        seen_word.data  = data_word_i;
        seen_word.nb    = valid_bytes_i;
        seen_word.first = is_first_i;
        seen_word.last  = is_last_i;
        seen_word.len   = total_length_i;
        absorb_word(seen_word);
        accepted_cnt++;
      end
      out_hold_n = (out_hold > 0) ? out_hold - 1 : 0;
      if (out_valid_o && !out_stall_i) begin
        if (hash_q.size() == 0) begin
          report("hash with none pending", hash_value_o, '0);
        end else begin
          want_hash = hash_q.pop_front();
          if (hash_value_o !== want_hash) report("hash_value", hash_value_o, want_hash);
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_hold_n = out_calm ? 0 : $urandom_range(0, 14);
      end else if (out_hold_n == 0 && !out_calm && $urandom_range(0, 7) == 0) begin
        out_hold_n = $urandom_range(1, 14);
      end
      out_hold    <= out_hold_n;
      out_stall_i <= (out_hold_n != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("murmur2_hash_engine: mismatch");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] rand_data();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    logic [31:0] r;
    r = $urandom();
    return r[LenW-1:0];
  endfunction

  task automatic push_word(input bit first, input bit last, input logic [NbW-1:0] nb,
                           input logic [LenW-1:0] len, input logic [WordW-1:0] data);
    msg_word_t w;
    w.data  = data;
    w.nb    = nb;
    w.first = first;
    w.last  = last;
    w.len   = len;
    if (first || gen_open) useful_cnt++;
    if (first) gen_open = 1'b1;
    if (last) gen_open = 1'b0;
    issued_cnt++;
    word_q.push_back(w);
  endtask

  task automatic push_msg(input int n, input int last_nb, input bit bad_len,
                          input bit bad_mid, input bit bad_last, input bit close);
    logic [LenW-1:0] len;
    logic [NbW-1:0]  nb;
    bit              last;
    len = bad_len ? rand_len() : LenW'((n - 1) * 4 + last_nb);
    for (int i = 0; i < n; i++) begin
      last = close && (i == n - 1);
      if (last) nb = bad_last ? NbW'($urandom_range(5, 7)) : NbW'(last_nb);
      else if (bad_mid && $urandom_range(0, 1) == 0) nb = NbW'($urandom_range(0, 7));
      else nb = 3'd4;
      push_word(i == 0, last, nb, (i == 0) ? len : rand_len(), rand_data());
    end
  endtask

  task automatic gen_random(input int unsigned target);
    int unsigned stop_at;
    int          r;
    int          n;
    stop_at = useful_cnt + target;
    while (useful_cnt < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6 && !gen_open) begin
        push_word(1'b0, $urandom_range(0, 1) == 1, NbW'($urandom_range(0, 7)), rand_len(),
                  rand_data());
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        push_msg(n, $urandom_range(0, 4), $urandom_range(0, 6) == 0,
                 $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, r >= 12);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (!(accepted_cnt == issued_cnt && hash_q.size() == 0));
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [WordW-1:0] s);
    @(posedge clk_i);
    hash_seed_we_i <= 1'b1;
    hash_seed_i    <= s;
    seed_mdl = s;
    @(posedge clk_i);
    hash_seed_we_i <= 1'b0;
  endtask

  logic [WordW-1:0] seed_list[5];

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-word messages over every tail size, extremes of data and length
    push_word(1'b1, 1'b1, 3'd0, '0, '1);
    push_word(1'b1, 1'b1, 3'd1, 31'd1, '1);
    push_word(1'b1, 1'b1, 3'd2, 31'd2, '0);
    push_word(1'b1, 1'b1, 3'd3, 31'd3, 32'ha5a5_a5a5);
    push_word(1'b1, 1'b1, 3'd4, 31'd4, '1);
    push_word(1'b1, 1'b1, 3'd3, '1, 32'h1234_5678);
    // words with no message open are dropped
    push_word(1'b0, 1'b1, 3'd2, '1, '1);
    push_word(1'b0, 1'b0, 3'd4, '0, 32'hdead_beef);
    // length mismatch, short non-last word, oversized last count
    push_word(1'b1, 1'b0, 3'd4, '1, 32'h0102_0304);
    push_word(1'b0, 1'b0, 3'd0, '0, 32'hffff_0000);
    push_word(1'b0, 1'b1, 3'd7, '0, 32'h8000_0001);
    // restart abandons the open message
    push_word(1'b1, 1'b0, 3'd4, 31'd8, 32'hcafe_f00d);
    push_word(1'b1, 1'b0, 3'd4, 31'd10, 32'h0bad_c0de);
    push_word(1'b0, 1'b0, 3'd4, 31'd10, 32'h7777_7777);
    push_word(1'b0, 1'b1, 3'd2, 31'd10, 32'hffff_ffff);
    // normal multi-word message
    push_word(1'b1, 1'b0, 3'd4, 31'd11, 32'h6c6c_6548);
    push_word(1'b0, 1'b0, 3'd4, 31'd11, 32'h6f57_206f);
    push_word(1'b0, 1'b1, 3'd3, 31'd11, 32'h0064_6c72);
    push_word(1'b1, 1'b1, 3'd5, 31'd4, 32'h5555_aaaa);
    push_word(1'b1, 1'b1, 3'd6, 31'd4, 32'haaaa_5555);
    push_word(1'b1, 1'b1, 3'd0, 31'd0, 32'h0000_0000);
    wait_idle();

    seed_list[0] = '1;
    seed_list[1] = '0;
    seed_list[2] = $urandom();
    seed_list[3] = 32'h8000_0000;
    seed_list[4] = $urandom();
    foreach (seed_list[i]) begin
      write_seed(seed_list[i]);
      push_msg(1, 0, 1'b0, 1'b0, 1'b0, 1'b1);
      gen_random(82);
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("murmur2_hash_engine: match");
    end else begin
      $display("murmur2_hash_engine: mismatch");
    end
    $finish;
  end

endmodule
